// ===== sv/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, constants and types of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int MAX_DIVISIONS = 1024;
    localparam int FRACTION_BITS = 16;

    localparam int CNT_W     = 11;
    localparam int IDX_W     = 11;
    localparam int RAD_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 17;
    localparam int NORM_W    = 16;
    localparam int TEX_W     = 17;
    localparam int ANG_W     = 32;
    localparam int QUO_W     = ANG_W + 1;
    localparam int MAG_W     = 31;

    localparam int DIV_STAGES  = 8;
    localparam int DIV_BITS    = ANG_W / DIV_STAGES;
    localparam int TRIG_STAGES = 22;

    localparam logic [31:0] PI_QUARTER_Q32 = 32'd3373259426;

    localparam int HORNER_STEPS = 6;
    localparam int SIN_STEPS    = 5;

    // Horner divisors and their reciprocals, floor(2^sh / d)
    localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam int         SIN_SH  [SIN_STEPS] = '{39, 39, 38, 37, 35};
    localparam logic [32:0] SIN_RCP [SIN_STEPS] = '{
        33'((65'd1 << 39) / 65'd110),
        33'((65'd1 << 39) / 65'd72),
        33'((65'd1 << 38) / 65'd42),
        33'((65'd1 << 37) / 65'd20),
        33'((65'd1 << 35) / 65'd6)
    };

    localparam logic [7:0] COS_DIV [HORNER_STEPS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam int         COS_SH  [HORNER_STEPS] = '{40, 39, 38, 37, 36, 33};
    localparam logic [32:0] COS_RCP [HORNER_STEPS] = '{
        33'((65'd1 << 40) / 65'd132),
        33'((65'd1 << 39) / 65'd90),
        33'((65'd1 << 38) / 65'd56),
        33'((65'd1 << 37) / 65'd30),
        33'((65'd1 << 36) / 65'd12),
        33'((65'd1 << 33) / 65'd2)
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STACK_COUNT   = 2'd0,
        CFG_SECTOR_COUNT  = 2'd1,
        CFG_SPHERE_RADIUS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_sgnmag;

    typedef struct packed {
        t_sgnmag sn;
        t_sgnmag cs;
    } t_trig_out;

    typedef struct packed {
        logic [1:0]  quad;
        logic        swap;
        logic [31:0] x;
        logic [31:0] x2;
    } t_trig_ctl;

    typedef struct packed {
        logic [TEX_W-1:0] u;
        logic [TEX_W-1:0] v;
    } t_tex;

endpackage

// ===== sv/uvs_grid_if.sv =====
// ----------------------------------------------------------------------------
// uvs_grid_if
// Grid point channel: stack and sector index with valid/ready.
// ----------------------------------------------------------------------------
interface uvs_grid_if;
    logic                      valid;
    logic                      ready;
    logic [uvs_pkg::IDX_W-1:0] stack_index;
    logic [uvs_pkg::IDX_W-1:0] sector_index;

    modport source (output valid, output stack_index, output sector_index, input ready);
    modport sink   (input valid, input stack_index, input sector_index, output ready);
endinterface

// ===== sv/uvs_vertex_if.sv =====
// ----------------------------------------------------------------------------
// uvs_vertex_if
// Vertex channel: position, normal and texture coordinates with valid/ready.
// ----------------------------------------------------------------------------
interface uvs_vertex_if;
    logic                              valid;
    logic                              ready;
    logic signed [uvs_pkg::POS_W-1:0]  pos_x;
    logic signed [uvs_pkg::POS_W-1:0]  pos_y;
    logic signed [uvs_pkg::POS_W-1:0]  pos_z;
    logic signed [uvs_pkg::NORM_W-1:0] norm_x;
    logic signed [uvs_pkg::NORM_W-1:0] norm_y;
    logic signed [uvs_pkg::NORM_W-1:0] norm_z;
    logic        [uvs_pkg::TEX_W-1:0]  tex_u;
    logic        [uvs_pkg::TEX_W-1:0]  tex_v;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output norm_x, output norm_y, output norm_z,
                    output tex_u, output tex_v, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input norm_x, input norm_y, input norm_z,
                    input tex_u, input tex_v, output ready);
endinterface

// ===== sv/uvs_div.sv =====
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider: floor(idx * 2^32 / cnt) for idx <= cnt.
// ----------------------------------------------------------------------------
module uvs_div (
    input  logic                           i_clk,
    input  logic [uvs_pkg::DIV_STAGES-1:0] i_en,
    input  logic [uvs_pkg::IDX_W-1:0]      i_idx,
    input  logic [uvs_pkg::CNT_W-1:0]      i_cnt,
    output logic [uvs_pkg::QUO_W-1:0]      o_quo
);
    import uvs_pkg::*;

    logic [CNT_W-1:0] r_rem  [DIV_STAGES];
    logic [ANG_W-1:0] r_frac [DIV_STAGES];
    logic             r_one  [DIV_STAGES];

    logic [CNT_W-1:0] s_rem  [DIV_STAGES+1];
    logic [ANG_W-1:0] s_frac [DIV_STAGES+1];
    logic             s_one  [DIV_STAGES+1];

    // idx == cnt is the whole turn; remainder starts at zero so the fraction is zero
    assign s_one[0]  = (i_idx == i_cnt);
    assign s_rem[0]  = s_one[0] ? '0 : i_idx;
    assign s_frac[0] = '0;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [CNT_W-1:0] n_rem;
        logic [ANG_W-1:0] n_frac;

        always_comb begin
            logic [CNT_W:0] dbl;
            n_rem  = s_rem[k];
            n_frac = s_frac[k];
            for (int b = 0; b < DIV_BITS; b++) begin
                dbl = {n_rem, 1'b0};
                if (dbl >= {1'b0, i_cnt}) begin
                    n_rem  = CNT_W'(dbl - {1'b0, i_cnt});
                    n_frac = {n_frac[ANG_W-2:0], 1'b1};
                end else begin
                    n_rem  = dbl[CNT_W-1:0];
                    n_frac = {n_frac[ANG_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k]  <= n_rem;
                r_frac[k] <= n_frac;
                r_one[k]  <= s_one[k];
            end
        end

        assign s_rem[k+1]  = r_rem[k];
        assign s_frac[k+1] = r_frac[k];
        assign s_one[k+1]  = r_one[k];
    end

    assign o_quo = {s_one[DIV_STAGES], s_frac[DIV_STAGES]};

endmodule

// ===== sv/uvs_trig.sv =====
// ----------------------------------------------------------------------------
// uvs_trig
// Pipelined sine and cosine of an angle in turns, Q30 sign and magnitude.
// ----------------------------------------------------------------------------
module uvs_trig (
    input  logic                            i_clk,
    input  logic [uvs_pkg::TRIG_STAGES-1:0] i_en,
    input  logic [uvs_pkg::ANG_W-1:0]       i_ang,
    output uvs_pkg::t_trig_out              o_res
);
    import uvs_pkg::*;

    localparam int          HS        = HORNER_STEPS * 3;
    localparam logic [32:0] Q32_ONE   = 33'h1_0000_0000;
    localparam logic [30:0] QUAD_SPAN = 31'h4000_0000;

    logic [1:0]  r_quad1;
    logic        r_swap1;
    logic [29:0] r_oct;
    logic [1:0]  r_quad2;
    logic        r_swap2;
    logic [31:0] r_x;
    t_trig_ctl   r_hc;

    t_trig_ctl   r_ctl [HS];
    t_trig_ctl   s_ctl [HS+1];
    logic [32:0] r_t_s [HORNER_STEPS];
    logic [32:0] r_t_c [HORNER_STEPS];
    logic [32:0] s_t_s [HORNER_STEPS+1];
    logic [32:0] s_t_c [HORNER_STEPS+1];

    t_trig_out   r_res;

    // octant reduction, then x in Q32 radians and x^2
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_quad1 <= i_ang[31:30];
            r_swap1 <= i_ang[29];
            r_oct   <= i_ang[29] ? 30'(QUAD_SPAN - {1'b0, i_ang[29:0]}) : i_ang[29:0];
        end
        if (i_en[1]) begin
            r_quad2 <= r_quad1;
            r_swap2 <= r_swap1;
            r_x     <= 32'((62'(r_oct) * 62'(PI_QUARTER_Q32)) >> 29);
        end
        if (i_en[2]) begin
            r_hc.quad <= r_quad2;
            r_hc.swap <= r_swap2;
            r_hc.x    <= r_x;
            r_hc.x2   <= 32'((64'(r_x) * 64'(r_x)) >> 32);
        end
    end

    assign s_ctl[0] = r_hc;
    assign s_t_s[0] = Q32_ONE;
    assign s_t_c[0] = Q32_ONE;

    for (genvar i = 0; i < HS; i++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (i_en[3+i]) begin
                r_ctl[i] <= s_ctl[i];
            end
        end
        assign s_ctl[i+1] = r_ctl[i];
    end

    // each Horner term: multiply, reciprocal multiply, correct and subtract
    for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_step
        logic [31:0] r_pa_c;
        logic [31:0] r_pb_c;
        logic [31:0] r_q0_c;
        logic [31:0] w_q_c;

        always_comb begin
            logic [40:0] rem;
            rem   = 41'(r_pb_c) - 41'(r_q0_c) * 41'(COS_DIV[j]);
            w_q_c = r_q0_c + 32'(rem >= 41'(COS_DIV[j]));
        end

        always_ff @(posedge i_clk) begin
            if (i_en[3+3*j]) begin
                r_pa_c <= 32'((65'(s_ctl[3*j].x2) * 65'(s_t_c[j])) >> 32);
            end
            if (i_en[4+3*j]) begin
                r_pb_c <= r_pa_c;
                r_q0_c <= 32'((65'(r_pa_c) * 65'(COS_RCP[j])) >> COS_SH[j]);
            end
            if (i_en[5+3*j]) begin
                r_t_c[j] <= Q32_ONE - 33'(w_q_c);
            end
        end

        if (j < SIN_STEPS) begin : g_sin
            logic [31:0] r_pa_s;
            logic [31:0] r_pb_s;
            logic [31:0] r_q0_s;
            logic [31:0] w_q_s;

            always_comb begin
                logic [40:0] rem;
                rem   = 41'(r_pb_s) - 41'(r_q0_s) * 41'(SIN_DIV[j]);
                w_q_s = r_q0_s + 32'(rem >= 41'(SIN_DIV[j]));
            end

            always_ff @(posedge i_clk) begin
                if (i_en[3+3*j]) begin
                    r_pa_s <= 32'((65'(s_ctl[3*j].x2) * 65'(s_t_s[j])) >> 32);
                end
                if (i_en[4+3*j]) begin
                    r_pb_s <= r_pa_s;
                    r_q0_s <= 32'((65'(r_pa_s) * 65'(SIN_RCP[j])) >> SIN_SH[j]);
                end
                if (i_en[5+3*j]) begin
                    r_t_s[j] <= Q32_ONE - 33'(w_q_s);
                end
            end
        end else begin : g_sin_fin
            // sine closes with x * t while cosine runs its last term
            logic [31:0] r_pa_s;
            logic [31:0] r_pb_s;

            always_ff @(posedge i_clk) begin
                if (i_en[3+3*j]) begin
                    r_pa_s <= 32'((65'(s_ctl[3*j].x) * 65'(s_t_s[j])) >> 32);
                end
                if (i_en[4+3*j]) begin
                    r_pb_s <= r_pa_s;
                end
                if (i_en[5+3*j]) begin
                    r_t_s[j] <= 33'(r_pb_s);
                end
            end
        end

        assign s_t_s[j+1] = r_t_s[j];
        assign s_t_c[j+1] = r_t_c[j];
    end

    // octant swap, round to Q30, quadrant signs
    logic [MAG_W-1:0] w_sw;
    logic [MAG_W-1:0] w_cw;

    always_comb begin
        logic [32:0] sraw;
        logic [32:0] craw;
        sraw = r_ctl[HS-1].swap ? r_t_c[HORNER_STEPS-1] : r_t_s[HORNER_STEPS-1];
        craw = r_ctl[HS-1].swap ? r_t_s[HORNER_STEPS-1] : r_t_c[HORNER_STEPS-1];
        w_sw = MAG_W'((34'(sraw) + 34'd2) >> 2);
        w_cw = MAG_W'((34'(craw) + 34'd2) >> 2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[TRIG_STAGES-1]) begin
            r_res.sn.neg <= r_ctl[HS-1].quad[1];
            r_res.sn.mag <= r_ctl[HS-1].quad[0] ? w_cw : w_sw;
            r_res.cs.neg <= r_ctl[HS-1].quad[1] ^ r_ctl[HS-1].quad[0];
            r_res.cs.mag <= r_ctl[HS-1].quad[0] ? w_sw : w_cw;
        end
    end

    assign o_res = r_res;

endmodule

// ===== sv/uv_sphere_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Grid point in, UV sphere vertex out: position, unit normal, texture coords.
// ----------------------------------------------------------------------------
// One vertex per clock sustained while the output is ready. One input register,
// eight divider stages (four quotient bits each, for u and v in parallel),
// 22 trig stages (octant reduction, then three stages per Horner term of the
// sine and cosine series, then a swap and rounding stage) and three stages
// for the normal product, rounding and radius scaling. Every stage has its
// own valid bit, so a stalled output only holds the stages that are full
// and bubbles close up behind it. Configuration is taken at any time but
// should only change while the pipeline is empty.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [uvs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [uvs_pkg::CFG_W-1:0]     i_cfg_data,
    uvs_grid_if.sink                      i_grid,
    uvs_vertex_if.source                  o_vertex
);
    import uvs_pkg::*;

    localparam int DIV_BASE  = 1;
    localparam int TRIG_BASE = DIV_BASE + DIV_STAGES;
    localparam int CMB_BASE  = TRIG_BASE + TRIG_STAGES;
    localparam int N_STAGES  = CMB_BASE + 3;
    localparam int PROD_W    = MAG_W + RAD_W;
    localparam int TEX_SH    = ANG_W - FRACTION_BITS;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        if (c == '0) begin
            return CNT_W'(1);
        end
        if (32'(c) > 32'(MAX_DIVISIONS)) begin
            return CNT_W'(MAX_DIVISIONS);
        end
        return c;
    endfunction

    function automatic t_sgnmag mul_q30(input t_sgnmag a, input t_sgnmag b);
        t_sgnmag r;
        r.neg = a.neg ^ b.neg;
        r.mag = MAG_W'((63'(a.mag) * 63'(b.mag) + 63'h2000_0000) >> 30);
        return r;
    endfunction

    // configuration
    logic [CNT_W-1:0] r_stack_count;
    logic [CNT_W-1:0] r_sector_count;
    logic [RAD_W-1:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count  <= CNT_W'(16);
            r_sector_count <= CNT_W'(32);
            r_radius       <= RAD_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STACK_COUNT:   r_stack_count  <= i_cfg_data[CNT_W-1:0];
                CFG_SECTOR_COUNT:  r_sector_count <= i_cfg_data[CNT_W-1:0];
                CFG_SPHERE_RADIUS: r_radius       <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and enables
    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES-1:0] w_en;
    logic [N_STAGES-1:0] w_vin;

    for (genvar k = 0; k < N_STAGES; k++) begin : g_en
        assign w_en[k] = !(&r_v[N_STAGES-1:k]) || o_vertex.ready;
    end

    assign w_vin = {r_v[N_STAGES-2:0], i_grid.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    assign i_grid.ready = w_en[0];

    // input register: clamp indices to the effective counts
    logic [CNT_W-1:0] w_ns;
    logic [CNT_W-1:0] w_nt;
    logic [IDX_W-1:0] r_s0_is;
    logic [IDX_W-1:0] r_s0_it;

    assign w_ns = eff_count(r_stack_count);
    assign w_nt = eff_count(r_sector_count);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_is <= (i_grid.stack_index > w_ns) ? w_ns : i_grid.stack_index;
            r_s0_it <= (i_grid.sector_index > w_nt) ? w_nt : i_grid.sector_index;
        end
    end

    // turns as 2^32 fractions
    logic [QUO_W-1:0] w_q_phi;
    logic [QUO_W-1:0] w_q_th;

    uvs_div u_div_phi (
        .i_clk (i_clk),
        .i_en  (w_en[DIV_BASE +: DIV_STAGES]),
        .i_idx (r_s0_is),
        .i_cnt (w_ns),
        .o_quo (w_q_phi)
    );

    uvs_div u_div_th (
        .i_clk (i_clk),
        .i_en  (w_en[DIV_BASE +: DIV_STAGES]),
        .i_idx (r_s0_it),
        .i_cnt (w_nt),
        .o_quo (w_q_th)
    );

    // phi covers half a turn
    t_trig_out w_phi;
    t_trig_out w_th;

    uvs_trig u_trig_phi (
        .i_clk (i_clk),
        .i_en  (w_en[TRIG_BASE +: TRIG_STAGES]),
        .i_ang (w_q_phi[QUO_W-1:1]),
        .o_res (w_phi)
    );

    uvs_trig u_trig_th (
        .i_clk (i_clk),
        .i_en  (w_en[TRIG_BASE +: TRIG_STAGES]),
        .i_ang (w_q_th[ANG_W-1:0]),
        .o_res (w_th)
    );

    // texture coordinates ride alongside the trig stages
    t_tex r_tex [TRIG_STAGES];
    t_tex s_tex [TRIG_STAGES+1];

    assign s_tex[0].u = TEX_W'(w_q_th >> TEX_SH);
    assign s_tex[0].v = TEX_W'(w_q_phi >> TEX_SH);

    for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_tex
        always_ff @(posedge i_clk) begin
            if (w_en[TRIG_BASE+k]) begin
                r_tex[k] <= s_tex[k];
            end
        end
        assign s_tex[k+1] = r_tex[k];
    end

    // normal products; components in x, y, z order
    t_sgnmag r_c1 [3];
    t_tex    r_c1_tex;

    always_ff @(posedge i_clk) begin
        if (w_en[CMB_BASE]) begin
            r_c1[0]  <= mul_q30(w_phi.sn, w_th.cs);
            r_c1[1]  <= w_phi.cs;
            r_c1[2]  <= mul_q30(w_phi.sn, w_th.sn);
            r_c1_tex <= s_tex[TRIG_STAGES];
        end
    end

    // normal rounding with saturation at +1.0, radius product
    logic [NORM_W-1:0] r_c2_norm [3];
    logic [PROD_W-1:0] r_c2_prod [3];
    logic              r_c2_neg  [3];
    t_tex              r_c2_tex;
    logic [NORM_W-1:0] w_norm    [3];

    always_comb begin
        logic [NORM_W:0] m;
        for (int c = 0; c < 3; c++) begin
            m = (NORM_W+1)'((32'(r_c1[c].mag) + 32'h4000) >> 15);
            if (!r_c1[c].neg && m > 17'd32767) begin
                m = 17'd32767;
            end
            w_norm[c] = NORM_W'(r_c1[c].neg ? (~m + 17'd1) : m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[CMB_BASE+1]) begin
            for (int c = 0; c < 3; c++) begin
                r_c2_norm[c] <= w_norm[c];
                r_c2_prod[c] <= PROD_W'(r_c1[c].mag) * PROD_W'(r_radius);
                r_c2_neg[c]  <= r_c1[c].neg;
            end
            r_c2_tex <= r_c1_tex;
        end
    end

    // position rounding and sign, output register
    logic [POS_W-1:0]  r_c3_pos  [3];
    logic [NORM_W-1:0] r_c3_norm [3];
    t_tex              r_c3_tex;
    logic [POS_W-1:0]  w_pos     [3];

    always_comb begin
        logic [POS_W-1:0] m;
        for (int c = 0; c < 3; c++) begin
            m = POS_W'(((PROD_W+1)'(r_c2_prod[c]) + (PROD_W+1)'(48'h2000_0000)) >> 30);
            w_pos[c] = r_c2_neg[c] ? (~m + 17'd1) : m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[CMB_BASE+2]) begin
            for (int c = 0; c < 3; c++) begin
                r_c3_pos[c]  <= w_pos[c];
                r_c3_norm[c] <= r_c2_norm[c];
            end
            r_c3_tex <= r_c2_tex;
        end
    end

    assign o_vertex.valid  = r_v[N_STAGES-1];
    assign o_vertex.pos_x  = r_c3_pos[0];
    assign o_vertex.pos_y  = r_c3_pos[1];
    assign o_vertex.pos_z  = r_c3_pos[2];
    assign o_vertex.norm_x = r_c3_norm[0];
    assign o_vertex.norm_y = r_c3_norm[1];
    assign o_vertex.norm_z = r_c3_norm[2];
    assign o_vertex.tex_u  = r_c3_tex.u;
    assign o_vertex.tex_v  = r_c3_tex.v;

endmodule

// ===== tb/tb_uv_sphere_vertex_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uv_sphere_vertex_generator
// Drives grid points with random gaps and output back-pressure across a range
// of count and radius settings, and checks every vertex beat field by field
// against a fixed-point sine/cosine predictor held in the bench or against directed values.
// ----------------------------------------------------------------------------
module tb_uv_sphere_vertex_generator;
    import uvs_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 40;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;   // unmapped register index
    localparam longint unsigned Q32     = 64'd4294967296;
    localparam longint unsigned PIQ_Q32 = 64'd3373259426;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic [TEX_W-1:0]         tex_u;
        logic [TEX_W-1:0]         tex_v;
    } vertex_t;

    typedef struct {
        bit              neg;
        longint unsigned mag;
    } smag_t;

    typedef struct {
        logic [IDX_W-1:0] stack_idx;
        logic [IDX_W-1:0] sector_idx;
        bit               known;
        vertex_t          vtx;
    } grid_row_t;

    typedef struct {
        logic [CFG_W-1:0] stacks;
        logic [CFG_W-1:0] sectors;
        logic [CFG_W-1:0] radius;
    } sphere_cfg_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    uvs_grid_if   grid ();
    uvs_vertex_if vtx ();

    uv_sphere_vertex_generator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_grid     (grid.sink),
        .o_vertex   (vtx.source)
    );

    // bench copy of the registers
    longint unsigned stacks_reg, sectors_reg, radius_reg;

    vertex_t pending_vertices[$];
    int      errors;
    int      points_sent;
    int      vertices_seen;
    int      cycles;
    bit      no_idle;

    longint unsigned SIN_D [5] = '{110, 72, 42, 20, 6};
    longint unsigned COS_D [6] = '{132, 90, 56, 30, 12, 2};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned clamp_count(longint unsigned c);
        if (c == 0) return 1;
        if (c > MAX_DIVISIONS) return MAX_DIVISIONS;
        return c;
    endfunction

    // r in units of 2^-29 octant; results in Q32
    function automatic void octant_sincos(input longint unsigned r,
                                          output longint unsigned s,
                                          output longint unsigned c);
        longint unsigned x, x2, t;
        x  = (r * PIQ_Q32) >> 29;
        x2 = (x * x) >> 32;
        t  = Q32;
        for (int k = 0; k < 5; k++) t = Q32 - ((x2 * t) >> 32) / SIN_D[k];
        s = (x * t) >> 32;
        t = Q32;
        for (int k = 0; k < 6; k++) t = Q32 - ((x2 * t) >> 32) / COS_D[k];
        c = t;
    endfunction

    function automatic void turn_sincos(input logic [31:0] ang,
                                        output smag_t s, output smag_t c);
        longint unsigned w, ps, pc, sw, cw;
        w = ang[29:0];
        if (w < (64'd1 << 29)) begin
            octant_sincos(w, ps, pc);
            sw = ps; cw = pc;
        end else begin
            octant_sincos((64'd1 << 30) - w, ps, pc);
            sw = pc; cw = ps;
        end
        sw = (sw + 2) >> 2;
        cw = (cw + 2) >> 2;
        case (ang[31:30])
            2'd0: begin s = '{0, sw}; c = '{0, cw}; end
            2'd1: begin s = '{0, cw}; c = '{1, sw}; end
            2'd2: begin s = '{1, sw}; c = '{1, cw}; end
            default: begin s = '{1, cw}; c = '{0, sw}; end
        endcase
    endfunction

    function automatic smag_t mul_q30(smag_t a, smag_t b);
        smag_t r;
        r.neg = a.neg ^ b.neg;
        r.mag = (a.mag * b.mag + (64'd1 << 29)) >> 30;
        return r;
    endfunction

    function automatic logic [NORM_W-1:0] normal_field(smag_t n);
        longint unsigned m;
        m = (n.mag + (64'd1 << 14)) >> 15;
        if (!n.neg && m > 32767) m = 32767;
        if (n.neg && m > 32768) m = 32768;
        return NORM_W'(n.neg ? -m : m);
    endfunction

    function automatic logic [POS_W-1:0] position_field(smag_t n);
        longint unsigned m;
        m = (n.mag * radius_reg + (64'd1 << 29)) >> 30;
        return POS_W'(n.neg ? -m : m);
    endfunction

    function automatic vertex_t sphere_vertex(logic [IDX_W-1:0] si, logic [IDX_W-1:0] ti);
        longint unsigned ns, nt, is, it;
        logic [31:0] phi, theta;
        smag_t sp, cp, st, ct, nx, nz;
        vertex_t v;
        ns = clamp_count(stacks_reg);
        nt = clamp_count(sectors_reg);
        is = (si > ns) ? ns : si;
        it = (ti > nt) ? nt : ti;
        phi   = 32'((is << 31) / ns);
        theta = 32'((it << 32) / nt);
        turn_sincos(phi, sp, cp);
        turn_sincos(theta, st, ct);
        nx = mul_q30(sp, ct);
        nz = mul_q30(sp, st);
        v.pos_x  = position_field(nx);
        v.pos_y  = position_field(cp);
        v.pos_z  = position_field(nz);
        v.norm_x = normal_field(nx);
        v.norm_y = normal_field(cp);
        v.norm_z = normal_field(nz);
        v.tex_u  = TEX_W'((it << FRACTION_BITS) / nt);
        v.tex_v  = TEX_W'((is << FRACTION_BITS) / ns);
        return v;
    endfunction

    // ---------------- checking ----------------
    task automatic report(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d (vertex %0d)",
                 what, got, want, vertices_seen);
    endtask

    always @(posedge i_clk) begin
        vertex_t w;
        if (i_rst_n && vtx.valid && vtx.ready) begin
            if (pending_vertices.size() == 0) begin
                errors++;
                $display("MISMATCH unexpected vertex beat %0d", vertices_seen);
            end else begin
                w = pending_vertices.pop_front();
                if (vtx.pos_x !== w.pos_x)   report("pos_x", vtx.pos_x, w.pos_x);
                if (vtx.pos_y !== w.pos_y)   report("pos_y", vtx.pos_y, w.pos_y);
                if (vtx.pos_z !== w.pos_z)   report("pos_z", vtx.pos_z, w.pos_z);
                if (vtx.norm_x !== w.norm_x) report("norm_x", vtx.norm_x, w.norm_x);
                if (vtx.norm_y !== w.norm_y) report("norm_y", vtx.norm_y, w.norm_y);
                if (vtx.norm_z !== w.norm_z) report("norm_z", vtx.norm_z, w.norm_z);
                if (vtx.tex_u !== w.tex_u)   report("tex_u", vtx.tex_u, w.tex_u);
                if (vtx.tex_v !== w.tex_v)   report("tex_v", vtx.tex_v, w.tex_v);
            end
            vertices_seen++;
        end
    end

    // output back-pressure: fresh stall drawn after each beat
    int stall_left;
    always @(posedge i_clk) begin
        bit rdy;
        if (!i_rst_n) begin
            stall_left = 0;
            vtx.ready <= 1'b0;
        end else begin
            if (vtx.valid && vtx.ready) stall_left = no_idle ? 0 : $urandom_range(0, 10);
            rdy = (stall_left == 0);
            if (stall_left > 0) stall_left--;
            vtx.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_point(logic [IDX_W-1:0] si, logic [IDX_W-1:0] ti,
                              bit known, vertex_t typed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            grid.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        grid.valid        <= 1'b1;
        grid.stack_index  <= si;
        grid.sector_index <= ti;
        do @(posedge i_clk); while (!grid.ready);
        pending_vertices.insert(pending_vertices.size(),
                                known ? typed : sphere_vertex(si, ti));
        points_sent++;
    endtask

    // called at the edge that took the last beat, so valid drops there
    task automatic drain();
        grid.valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_STACK_COUNT:   stacks_reg  = data[CNT_W-1:0];
            CFG_SECTOR_COUNT:  sectors_reg = data[CNT_W-1:0];
            CFG_SPHERE_RADIUS: radius_reg  = data;
            default: ;
        endcase
    endtask

    // directed rows at reset settings (16 stacks, 32 sectors, radius 256)
    grid_row_t directed [14] = '{
        '{11'd0,    11'd0,    1'b1, '{17'sd0, 17'sd256, 17'sd0, 16'sd0, 16'sd32767, 16'sd0,
                                      17'd0, 17'd0}},
        '{11'd16,   11'd0,    1'b1, '{17'sd0, -17'sd256, 17'sd0, 16'sd0, -16'sd32768, 16'sd0,
                                      17'd0, 17'd65536}},
        '{11'd2047, 11'd2047, 1'b1, '{17'sd0, -17'sd256, 17'sd0, 16'sd0, -16'sd32768, 16'sd0,
                                      17'd65536, 17'd65536}},
        '{11'd8,    11'd0,    1'b1, '{17'sd256, 17'sd0, 17'sd0, 16'sd32767, 16'sd0, 16'sd0,
                                      17'd0, 17'd32768}},
        '{11'd8,    11'd8,    1'b1, '{17'sd0, 17'sd0, 17'sd256, 16'sd0, 16'sd0, 16'sd32767,
                                      17'd16384, 17'd32768}},
        '{11'd8,    11'd16,   1'b1, '{-17'sd256, 17'sd0, 17'sd0, -16'sd32768, 16'sd0, 16'sd0,
                                      17'd32768, 17'd32768}},
        '{11'd4,    11'd4,    1'b0, '0},
        '{11'd1,    11'd1,    1'b0, '0},
        '{11'd15,   11'd31,   1'b0, '0},
        '{11'd3,    11'd17,   1'b0, '0},
        '{11'd0,    11'd1024, 1'b0, '0},
        '{11'd1024, 11'd5,    1'b0, '0},
        '{11'd5,    11'd2047, 1'b0, '0},
        '{11'd12,   11'd24,   1'b0, '0}
    };

    sphere_cfg_t settings [8] = '{
        '{16'd1,     16'd1,     16'd65535},
        '{16'd0,     16'd0,     16'd0},
        '{16'd1024,  16'd1024,  16'd12345},
        '{16'hFFFF,  16'd2047,  16'd65535},
        '{16'd3,     16'd7,     16'd256},
        '{16'd1025,  16'd2,     16'd40000},
        '{16'd100,   16'd360,   16'd1},
        '{16'd16,    16'd32,    16'd256}
    };

    initial begin
        longint unsigned ns, nt;
        logic [IDX_W-1:0] si, ti;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_STACK_COUNT;
        i_cfg_data   <= '0;
        grid.valid        <= 1'b0;
        grid.stack_index  <= '0;
        grid.sector_index <= '0;
        stacks_reg  = 16;
        sectors_reg = 32;
        radius_reg  = 256;
        errors = 0; points_sent = 0; vertices_seen = 0; cycles = 0; no_idle = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r])
            send_point(directed[r].stack_idx, directed[r].sector_idx,
                       directed[r].known, directed[r].vtx);
        drain();

        foreach (settings[p]) begin
            cfg_write(CFG_STACK_COUNT,   settings[p].stacks);
            cfg_write(CFG_SECTOR_COUNT,  settings[p].sectors);
            cfg_write(CFG_SPHERE_RADIUS, settings[p].radius);
            if (p == 2) cfg_write(CFG_SPARE, 16'hA5A5);   // must be ignored
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            no_idle = (p % 3 == 1);
            ns = clamp_count(stacks_reg);
            nt = clamp_count(sectors_reg);
            for (int n = 0; n < 125; n++) begin
                if ($urandom_range(0, 4) == 0) begin
                    si = IDX_W'($urandom_range(0, 2047));
                    ti = IDX_W'($urandom_range(0, 2047));
                end else begin
                    si = IDX_W'($urandom_range(0, int'(ns)));
                    ti = IDX_W'($urandom_range(0, int'(nt)));
                end
                send_point(si, ti, 1'b0, '0);
                // hold off mid-phase until the pipe is empty
                if (n == 60 && p == 4) begin
                    drain();
                end
            end
            drain();
        end

        $display("Sent %0d grid points, checked %0d vertices over %0d count/radius settings",
                 points_sent, vertices_seen, $size(settings) + 1);
        $display("Covered pole and equator extremes, index clamping and zero/oversize counts");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/uvs_pkg.sv
sv/uvs_grid_if.sv
sv/uvs_vertex_if.sv
sv/uvs_div.sv
sv/uvs_trig.sv
sv/uv_sphere_vertex_generator.sv
tb/tb_uv_sphere_vertex_generator.sv
